// ----- src/sis_pkg.sv -----
// Shared constants and pipeline record types for the sine integral series unit.
// No dependencies.
package sis_pkg;

  localparam int FRAC_BITS   = 20;
  localparam int ARG_W       = 24;
  localparam int THR_W       = 21;
  localparam int OUT_W       = 22;
  localparam int CNT_W       = 6;
  // Term magnitudes stay below 60 * 2^FRAC_BITS for any 24-bit argument.
  localparam int MAG_W       = 26;
  localparam int X2_W        = 27;
  localparam int T_W         = 32;
  // Reciprocal scale: 2^RECIP_SHIFT >= T_max * largest denominator (64 terms).
  localparam int RECIP_SHIFT = 54;
  localparam int KLO_W       = 25;
  localparam int KHI_W       = 25;
  localparam int SUM_W       = 34;
  localparam int MAX_TERMS_DEF = 32;

  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic                    done;
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
    logic [X2_W-1:0]         x2;
  } term_ctl_t;

endpackage

// ----- src/sine_integral_series_unit.sv -----
// Sine integral Si(x) by Taylor series, one fully pipelined term per stage group.
// Depends on sis_pkg.
//
// Usage:
//   Input channel: argument (Q3.20 signed) with arg_valid / arg_stall. A transfer
//   happens on a rising edge with arg_valid high and arg_stall low.
//   Output channel: integral_value (Q1.20 signed, saturated), terms_used and
//   not_converged with res_valid / res_stall, same transfer rule.
//   stop_threshold is loaded on any edge with stop_threshold_write high; change
//   it only while no transfer is in flight.
// Throughput: one transfer per cycle unless the output stalls. Every term
//   of the series has three stages of its own: compare/accumulate plus x^2
//   multiply, a split reciprocal multiply, and the partial-product merge that
//   yields the next magnitude. All MAX_TERMS term groups are always traversed.
// Path: the input register, the term groups and the output register lie
//   between an input transfer and res_valid.
// Reset: rst (synchronous) clears all valid bits and sets stop_threshold to 1.
// Stall: when res_valid is high and res_stall is high, the whole pipeline
//   holds and arg_stall goes high; nothing is dropped or repeated.
module sine_integral_series_unit #(
  parameter int MAX_TERMS = sis_pkg::MAX_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            stop_threshold_write,
  input  logic [sis_pkg::THR_W-1:0]       stop_threshold,
  input  logic                            arg_valid,
  output logic                            arg_stall,
  input  logic signed [sis_pkg::ARG_W-1:0] argument,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic signed [sis_pkg::OUT_W-1:0] integral_value,
  output logic [sis_pkg::CNT_W-1:0]       terms_used,
  output logic                            not_converged
);
  import sis_pkg::*;

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(64'sd1 <<< (OUT_W - 1));
  localparam logic [CNT_W-1:0]        CNT_MAX = '1;

  logic [THR_W-1:0] thr;
  logic             en;

  // Stage records: a = term input, b = after x^2 multiply, c = after reciprocal.
  term_ctl_t              ctl_a [0:MAX_TERMS];
  logic [MAG_W-1:0]       mag_a [0:MAX_TERMS];
  term_ctl_t              ctl_b [0:MAX_TERMS-1];
  logic [T_W-1:0]         t_b   [0:MAX_TERMS-1];
  term_ctl_t              ctl_c [0:MAX_TERMS-1];
  logic [T_W+KLO_W-1:0]   plo_c [0:MAX_TERMS-1];
  logic [T_W+KHI_W-1:0]   phi_c [0:MAX_TERMS-1];

  assign en        = !(res_valid && res_stall);
  assign arg_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
    end else if (stop_threshold_write) begin
      thr <= stop_threshold;
    end
  end

  // Entry: magnitude of x and floor(x^2).
  logic                 in_neg;
  logic [ARG_W-1:0]     in_abs;
  logic [2*ARG_W-1:0]   in_sq;

  always_comb begin
    in_neg = argument[ARG_W-1];
    in_abs = in_neg ? ARG_W'(-argument) : ARG_W'(argument);
    in_sq  = in_abs * in_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a[0].valid <= 1'b0;
    end else if (en) begin
      ctl_a[0].valid <= arg_valid;
    end
    if (en) begin
      ctl_a[0].neg  <= in_neg;
      ctl_a[0].done <= 1'b0;
      ctl_a[0].cnt  <= '0;
      ctl_a[0].sum  <= '0;
      ctl_a[0].x2   <= in_sq[FRAC_BITS +: X2_W];
      mag_a[0]      <= MAG_W'(in_abs);
    end
  end

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_term
    // Next term index n = i+1: ratio (2n-1) / ((2n+1)^2 * 2n).
    localparam logic [63:0] NN    = 64'(i + 1);
    localparam logic [63:0] DEN   = (2 * NN + 1) * (2 * NN + 1) * (2 * NN);
    localparam logic [63:0] RECIP = (((2 * NN - 1) << RECIP_SHIFT) + DEN - 1) / DEN;
    localparam logic [KLO_W-1:0] K_LO = RECIP[KLO_W-1:0];
    localparam logic [KHI_W-1:0] K_HI = RECIP[KLO_W +: KHI_W];

    term_ctl_t                 acc;
    logic                      take;
    logic [MAG_W+X2_W-1:0]     prod;
    logic [T_W+KLO_W+KHI_W-1:0] merged;

    always_comb begin
      acc  = ctl_a[i];
      take = !ctl_a[i].done && (mag_a[i] >= MAG_W'(thr));
      if (take) begin
        if (ctl_a[i].neg ^ NN[0] ^ 1'b1) begin
          acc.sum = ctl_a[i].sum - SUM_W'(mag_a[i]);
        end else begin
          acc.sum = ctl_a[i].sum + SUM_W'(mag_a[i]);
        end
        if (ctl_a[i].cnt != CNT_MAX) begin
          acc.cnt = ctl_a[i].cnt + CNT_W'(1);
        end
      end else begin
        acc.done = 1'b1;
      end
      prod   = mag_a[i] * ctl_a[i].x2;
      merged = {phi_c[i], {KLO_W{1'b0}}} + (T_W+KLO_W+KHI_W)'(plo_c[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_b[i].valid   <= 1'b0;
        ctl_c[i].valid   <= 1'b0;
        ctl_a[i+1].valid <= 1'b0;
      end else if (en) begin
        ctl_b[i].valid   <= acc.valid;
        ctl_c[i].valid   <= ctl_b[i].valid;
        ctl_a[i+1].valid <= ctl_c[i].valid;
      end
      if (en) begin
        ctl_b[i].neg  <= acc.neg;
        ctl_b[i].done <= acc.done;
        ctl_b[i].cnt  <= acc.cnt;
        ctl_b[i].sum  <= acc.sum;
        ctl_b[i].x2   <= acc.x2;
        t_b[i]        <= prod[FRAC_BITS +: T_W];

        ctl_c[i].neg  <= ctl_b[i].neg;
        ctl_c[i].done <= ctl_b[i].done;
        ctl_c[i].cnt  <= ctl_b[i].cnt;
        ctl_c[i].sum  <= ctl_b[i].sum;
        ctl_c[i].x2   <= ctl_b[i].x2;
        plo_c[i]      <= t_b[i] * K_LO;
        phi_c[i]      <= t_b[i] * K_HI;

        ctl_a[i+1].neg  <= ctl_c[i].neg;
        ctl_a[i+1].done <= ctl_c[i].done;
        ctl_a[i+1].cnt  <= ctl_c[i].cnt;
        ctl_a[i+1].sum  <= ctl_c[i].sum;
        ctl_a[i+1].x2   <= ctl_c[i].x2;
        mag_a[i+1]      <= merged[RECIP_SHIFT +: MAG_W];
      end
    end
  end

  // Output: saturate the sum, flag an unfinished series.
  logic signed [SUM_W-1:0] fin_sum;
  logic                    fin_nc;

  always_comb begin
    fin_nc = !ctl_a[MAX_TERMS].done && (mag_a[MAX_TERMS] >= MAG_W'(thr));
    if (ctl_a[MAX_TERMS].sum > OUT_MAX) begin
      fin_sum = OUT_MAX;
    end else if (ctl_a[MAX_TERMS].sum < OUT_MIN) begin
      fin_sum = OUT_MIN;
    end else begin
      fin_sum = ctl_a[MAX_TERMS].sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= ctl_a[MAX_TERMS].valid;
    end
    if (en) begin
      integral_value <= fin_sum[OUT_W-1:0];
      terms_used     <= ctl_a[MAX_TERMS].cnt;
      not_converged  <= fin_nc;
    end
  end

endmodule

// ----- tb/sv/sine_integral_series_unit_tb.sv -----
// Self-checking testbench for sine_integral_series_unit: random and directed arguments
// against a behavioral series predictor, under several stop thresholds.
// Depends on sis_pkg and sine_integral_series_unit.
`timescale 1ns / 1ps

module sine_integral_series_unit_tb;
  import sis_pkg::*;

  localparam int TERM_LIMIT = 32;
  localparam int PIPE_LAT = 3 * TERM_LIMIT + 2;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic [CNT_W-1:0] terms;
    logic             nc;
  } si_result_t;

  logic clk, rst;
  logic stop_threshold_write;
  logic [THR_W-1:0] stop_threshold;
  logic arg_valid, arg_stall;
  logic signed [ARG_W-1:0] argument;
  logic res_valid, res_stall;
  logic signed [OUT_W-1:0] integral_value;
  logic [CNT_W-1:0] terms_used;
  logic not_converged;

  sine_integral_series_unit i_dut (
    .clk(clk), .rst(rst),
    .stop_threshold_write(stop_threshold_write), .stop_threshold(stop_threshold),
    .arg_valid(arg_valid), .arg_stall(arg_stall), .argument(argument),
    .res_valid(res_valid), .res_stall(res_stall),
    .integral_value(integral_value), .terms_used(terms_used),
    .not_converged(not_converged)
  );

  logic [ARG_W-1:0] pending_args[$];
  si_result_t       expected_si[$];
  longint unsigned  threshold_copy;
  int               error_count = 0;
  int               idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Series predictor: term magnitudes kept unsigned, sign tracked apart,
  // every intermediate clamped to 2^61.
  function automatic si_result_t predict_si(logic [ARG_W-1:0] raw, longint unsigned thr);
    longint unsigned cap, ax, x2, mag, t, odd, den, n;
    longint signed sum;
    bit neg;
    si_result_t r;
    cap = 64'd1 << 61;
    neg = raw[ARG_W-1];
    ax = neg ? ((64'd1 << ARG_W) - 64'(raw)) : 64'(raw);
    x2 = (ax * ax) >> FRAC_BITS;
    mag = ax;
    n = 0;
    sum = 0;
    while (n < TERM_LIMIT && mag >= thr) begin
      if (neg ^ n[0]) sum -= $signed(mag);
      else sum += $signed(mag);
      if (sum > $signed(cap)) sum = $signed(cap);
      if (sum < -$signed(cap)) sum = -$signed(cap);
      n++;
      // next magnitude: M * x^2 * (2n-1) / ((2n+1)^2 * 2n)
      if (x2 != 0 && mag > ('1 / x2)) t = cap;
      else t = (mag * x2) >> FRAC_BITS;
      if (t > cap) t = cap;
      odd = 2 * n - 1;
      den = (2 * n + 1) * (2 * n + 1) * (2 * n);
      if (t > ('1 / odd)) t = cap;
      else t = (t * odd) / den;
      if (t > cap) t = cap;
      mag = t;
    end
    if (sum > (64'sd1 <<< (OUT_W - 1)) - 1) sum = (64'sd1 <<< (OUT_W - 1)) - 1;
    if (sum < -(64'sd1 <<< (OUT_W - 1))) sum = -(64'sd1 <<< (OUT_W - 1));
    r.value = sum[OUT_W-1:0];
    r.terms = (n > 63) ? 6'd63 : n[CNT_W-1:0];
    r.nc = (n == TERM_LIMIT) && (mag >= thr);
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps; payload held while stalled.
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      arg_valid <= 1'b0;
      argument <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!arg_valid || !arg_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        arg_valid <= 1'b0;
      end else if (pending_args.size() > 0) begin
        arg_valid <= 1'b1;
        argument <= pending_args.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(80, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end else begin
        arg_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: modes of none, light and heavy stalling.
  int stall_mode, mode_left;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2, 0);
        mode_left = $urandom_range(300, 20);
      end
      mode_left--;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(9, 0) < 3);
        default: res_stall <= ($urandom_range(9, 0) < 7);
      endcase
    end
  end

  // Monitor: predict on every input transfer, check on every result transfer.
  always @(posedge clk) begin
    si_result_t want;
    if (rst) begin
      threshold_copy = 1;
      idle_cycles = 0;
    end else begin
      if (stop_threshold_write) threshold_copy = 64'(stop_threshold);
      if (arg_valid && !arg_stall) expected_si.push_back(predict_si(argument, threshold_copy));
      if (res_valid && !res_stall) begin
        if (expected_si.size() == 0) begin
          $error("unexpected result transfer: integral_value %0d", integral_value);
          error_count++;
        end else begin
          want = expected_si.pop_front();
          if (integral_value !== want.value) begin
            $error("integral_value expected %0d got %0d", $signed(want.value), integral_value);
            error_count++;
          end
          if (terms_used !== want.terms) begin
            $error("terms_used expected %0d got %0d", want.terms, terms_used);
            error_count++;
          end
          if (not_converged !== want.nc) begin
            $error("not_converged expected %0d got %0d", want.nc, not_converged);
            error_count++;
          end
        end
      end
      // watchdog only runs while work is outstanding
      if ((arg_valid && !arg_stall) || (res_valid && !res_stall) ||
          (pending_args.size() == 0 && expected_si.size() == 0 && !arg_valid))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_args.size() != 0 || expected_si.size() != 0 || arg_valid)
      @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(posedge clk);
    stop_threshold <= v;
    stop_threshold_write <= 1'b1;
    @(posedge clk);
    stop_threshold_write <= 1'b0;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3, 0))
        0: pending_args.push_back(ARG_W'($urandom_range(8 * 1024, 0) - 4096));     // near zero
        1: pending_args.push_back(ARG_W'($urandom_range(8 << 20, 0) - (4 << 20))); // |x| <= 4
        default: pending_args.push_back(ARG_W'($urandom()));                        // full field
      endcase
    end
  endtask

  logic [THR_W-1:0] threshold_plan[6];

  initial begin
    rst <= 1'b1;
    stop_threshold_write <= 1'b0;
    stop_threshold <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, zero, +-1, +-pi, one LSB either side, 2, +-7, 0.5 and alternating bit patterns
    pending_args = {24'h000000, 24'h000001, 24'hffffff, 24'h7fffff, 24'h800000,
                    24'h100000, 24'hf00000, 24'h3243f7, 24'hcdbc09, 24'h200000,
                    24'h700000, 24'h900000, 24'h080000, 24'h555555, 24'haaaaaa};
    queue_random(200);
    wait_drained();

    // zero threshold forces every term; then range extremes and random picks
    threshold_plan = '{21'd0, 21'd1048576, 21'h1fffff, 21'd1,
                       THR_W'($urandom_range(4096, 1)), THR_W'($urandom_range(1048576, 1))};
    foreach (threshold_plan[p]) begin
      repeat (PIPE_LAT) @(posedge clk);
      write_threshold(threshold_plan[p]);
      pending_args.push_back(24'h7fffff);
      pending_args.push_back(24'h800000);
      pending_args.push_back(24'h000000);
      queue_random(180);
      wait_drained();
    end

    repeat (PIPE_LAT + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sis_pkg.sv
src/sine_integral_series_unit.sv
tb/sv/sine_integral_series_unit_tb.sv
